// ===== rtl/spq_pkg.sv =====
// shared codes, defaults and control type for the sorted priority queue
package spq_pkg;

   // default sizes
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int COST_BITS_DEFAULT  = 16;
   localparam int COORD_BITS_DEFAULT = 10;

   // request operation codes
   localparam int OP_BITS = 2;
   localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
   } spq_ctl_type;

endpackage

// ===== rtl/sorted_priority_queue_with_lookup_core.sv =====
// top level of the sorted priority queue with coordinate lookup
//
//   channel   direction  ports                        handshake
//   request   in         req_op .. req_pos_y          req_valid / req_stall
//   response  out        rsp_found .. rsp_is_empty    rsp_valid / rsp_stall
//
// push and pop first capture the request, then every cell of the chain
// compares and shifts at once. lookup waits in its own state until the
// registered first-match tree has settled through its depth.
// reset empties the queue at once; entry contents need no clearing.
// a stalled response holds the block in its final cycle until the response
// register frees up; no new request is taken while one is in work.
module sorted_priority_queue_with_lookup_core #(
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEFAULT,
   parameter int COST_BITS  = spq_pkg::COST_BITS_DEFAULT,
   parameter int COORD_BITS = spq_pkg::COORD_BITS_DEFAULT,
   parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [spq_pkg::OP_BITS-1:0] req_op,
   input  logic [COST_BITS-1:0]        req_total_cost,
   input  logic [COST_BITS-1:0]        req_path_cost,
   input  logic [COST_BITS-1:0]        req_estimate_cost,
   input  logic [COORD_BITS-1:0]       req_pos_x,
   input  logic [COORD_BITS-1:0]       req_pos_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [COST_BITS-1:0]        rsp_out_total_cost,
   output logic [COST_BITS-1:0]        rsp_out_path_cost,
   output logic [COST_BITS-1:0]        rsp_out_estimate_cost,
   output logic [COORD_BITS-1:0]       rsp_out_x,
   output logic [COORD_BITS-1:0]       rsp_out_y,
   output logic                        rsp_push_dropped,
   output logic [CNT_BITS-1:0]         rsp_entry_count,
   output logic                        rsp_is_empty
);

   localparam int ENTRY_BITS = 3 * COST_BITS + 2 * COORD_BITS;
   localparam int LEVELS     = $clog2(CAPACITY);
   localparam int WAIT       = LEVELS + 1;
   localparam int WAIT_BITS  = $clog2(WAIT + 1);
   localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(CAPACITY);
   localparam logic [WAIT_BITS-1:0] WAIT_DONE  = WAIT_BITS'(WAIT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [WAIT_BITS-1:0]        wait_ff, wait_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [spq_pkg::OP_BITS-1:0] op_ff;
   logic [ENTRY_BITS-1:0]       entry_ff;
   logic [COORD_BITS-1:0]       look_x_ff, look_y_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        found_ff, found_in;
   logic [ENTRY_BITS-1:0]       out_ff, out_in;
   logic                        dropped_ff, dropped_in;
   logic [CNT_BITS-1:0]         rcount_ff;

   spq_pkg::spq_ctl_type        ctl;
   logic                        req_take;
   logic                        rsp_free;
   logic                        fire;

   logic [ENTRY_BITS-1:0]       cell_entry [CAPACITY];
   logic                        cell_ge    [CAPACITY];
   logic                        cell_match [CAPACITY];
   logic [COST_BITS-1:0]        cell_cost  [CAPACITY];
   logic                        root_match;
   logic [COST_BITS-1:0]        root_cost;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_op;
         entry_ff  <= {req_total_cost, req_path_cost, req_estimate_cost,
                       req_pos_x, req_pos_y};
         look_x_ff <= req_pos_x;
         look_y_ff <= req_pos_y;
      end
   end

   // sequencer and result selection
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      ctl          = '0;
      fire         = 1'b0;
      found_in     = 1'b0;
      out_in       = '0;
      dropped_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wait_in  = '0;
               state_in = (req_op == spq_pkg::OP_LOOKUP) ? ST_LOOK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            fire = rsp_free;
            if (op_ff == spq_pkg::OP_PUSH) begin
               if (count_ff == FULL_COUNT) begin
                  dropped_in = 1'b1;
               end else begin
                  ctl.push = fire;
                  count_in = fire ? count_ff + CNT_BITS'(1) : count_ff;
               end
            end else if (op_ff == spq_pkg::OP_POP) begin
               if (count_ff != '0) begin
                  found_in = 1'b1;
                  out_in   = cell_entry[0];
                  ctl.pop  = fire;
                  count_in = fire ? count_ff - CNT_BITS'(1) : count_ff;
               end
            end
         end
         ST_LOOK: begin
            if (wait_ff != WAIT_DONE) begin
               wait_in = wait_ff + WAIT_BITS'(1);
            end else begin
               fire     = rsp_free;
               found_in = root_match;
               out_in   = {root_cost, {(ENTRY_BITS-COST_BITS){1'b0}}};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (fire) begin
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         found_ff   <= found_in;
         out_ff     <= out_in;
         dropped_ff <= dropped_in;
         rcount_ff  <= count_in;
      end
   end

   // chain of cells, lowest cost in cell zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  prev_ge;
      logic [ENTRY_BITS-1:0] prev_entry;
      logic [ENTRY_BITS-1:0] next_entry;
      if (i == 0) begin : g_first
         assign prev_ge    = 1'b0;
         assign prev_entry = '0;
      end else begin : g_mid
         assign prev_ge    = cell_ge[i-1];
         assign prev_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end
      spq_cell #(
         .INDEX      (i),
         .CAPACITY   (CAPACITY),
         .COST_BITS  (COST_BITS),
         .COORD_BITS (COORD_BITS),
         .CNT_BITS   (CNT_BITS),
         .ENTRY_BITS (ENTRY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .new_entry  (entry_ff),
         .look_x     (look_x_ff),
         .look_y     (look_y_ff),
         .prev_ge    (prev_ge),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .ge         (cell_ge[i]),
         .match      (cell_match[i]),
         .entry      (cell_entry[i])
      );
      assign cell_cost[i] = cell_entry[i][ENTRY_BITS-1 -: COST_BITS];
   end

   // first match in queue order
   spq_match_tree #(
      .CAPACITY  (CAPACITY),
      .COST_BITS (COST_BITS)
   ) u_tree (
      .clock      (clock),
      .leaf_match (cell_match),
      .leaf_cost  (cell_cost),
      .root_match (root_match),
      .root_cost  (root_cost)
   );

   // response ports
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = found_ff;
   assign rsp_out_total_cost    = out_ff[ENTRY_BITS-1 -: COST_BITS];
   assign rsp_out_path_cost     = out_ff[ENTRY_BITS-COST_BITS-1 -: COST_BITS];
   assign rsp_out_estimate_cost = out_ff[ENTRY_BITS-2*COST_BITS-1 -: COST_BITS];
   assign rsp_out_x             = out_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rsp_out_y             = out_ff[COORD_BITS-1:0];
   assign rsp_push_dropped      = dropped_ff;
   assign rsp_entry_count       = rcount_ff;
   assign rsp_is_empty          = (rcount_ff == '0);

endmodule

// ===== rtl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts left or right, compares keys
module spq_cell #(
   parameter int INDEX      = 0,
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEFAULT,
   parameter int COST_BITS  = spq_pkg::COST_BITS_DEFAULT,
   parameter int COORD_BITS = spq_pkg::COORD_BITS_DEFAULT,
   parameter int CNT_BITS   = $clog2(CAPACITY + 1),
   parameter int ENTRY_BITS = 3 * COST_BITS + 2 * COORD_BITS
) (
   input  logic                    clock,
   input  spq_pkg::spq_ctl_type    ctl,
   input  logic [CNT_BITS-1:0]     count,
   input  logic [ENTRY_BITS-1:0]   new_entry,
   input  logic [COORD_BITS-1:0]   look_x,
   input  logic [COORD_BITS-1:0]   look_y,
   input  logic                    prev_ge,
   input  logic [ENTRY_BITS-1:0]   prev_entry,
   input  logic [ENTRY_BITS-1:0]   next_entry,
   output logic                    ge,
   output logic                    match,
   output logic [ENTRY_BITS-1:0]   entry
);

   localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

   logic [ENTRY_BITS-1:0] entry_ff;
   logic [ENTRY_BITS-1:0] entry_in;
   logic                  valid;
   logic [COST_BITS-1:0]  my_key;
   logic [COST_BITS-1:0]  new_key;
   logic [COORD_BITS-1:0] my_x;
   logic [COORD_BITS-1:0] my_y;

   // field slices of the held entry
   assign my_key  = entry_ff[ENTRY_BITS-1 -: COST_BITS];
   assign new_key = new_entry[ENTRY_BITS-1 -: COST_BITS];
   assign my_x    = entry_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign my_y    = entry_ff[COORD_BITS-1:0];

   // occupied slots are the lowest ones
   assign valid = (count > MY_INDEX);

   // an empty slot or a key not below the new one gives way
   assign ge    = !valid || (my_key >= new_key);
   assign match = valid && (my_x == look_x) && (my_y == look_y);
   assign entry = entry_ff;

   // insert, shift right, or shift left
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (ge) begin
            entry_in = prev_ge ? prev_entry : new_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/spq_match_tree.sv =====
// registered first-match tree over the cells for coordinate lookup
module spq_match_tree #(
   parameter int CAPACITY  = spq_pkg::CAPACITY_DEFAULT,
   parameter int COST_BITS = spq_pkg::COST_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 leaf_match [CAPACITY],
   input  logic [COST_BITS-1:0] leaf_cost  [CAPACITY],
   output logic                 root_match,
   output logic [COST_BITS-1:0] root_cost
);

   localparam int LEVELS = $clog2(CAPACITY);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;

   logic                 found_ff [NODES];
   logic [COST_BITS-1:0] cost_ff  [NODES];

   // leaves capture the per-cell compare
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
         always_ff @(posedge clock) begin
            found_ff[LEAVES-1+i] <= leaf_match[i];
            cost_ff[LEAVES-1+i]  <= leaf_cost[i];
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            found_ff[LEAVES-1+i] <= 1'b0;
            cost_ff[LEAVES-1+i]  <= '0;
         end
      end
   end

   // inner nodes prefer the lower-index side
   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      always_ff @(posedge clock) begin
         found_ff[k] <= found_ff[2*k+1] || found_ff[2*k+2];
         cost_ff[k]  <= found_ff[2*k+1] ? cost_ff[2*k+1]
                      : (found_ff[2*k+2] ? cost_ff[2*k+2] : '0);
      end
   end

   assign root_match = found_ff[0];
   assign root_cost  = cost_ff[0];

endmodule

// ===== rtl/spq_checker.sv =====
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT,
   parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_found,
   input logic                rsp_push_dropped,
   input logic [CNT_BITS-1:0] rsp_entry_count,
   input logic                rsp_is_empty
);

   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   // a held response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // empty flag follows the count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   // a dropped push means a full queue and no entry
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |-> !rsp_found && (rsp_entry_count == FULL_COUNT))
      else $error("push dropped without full queue");

endmodule

bind sorted_priority_queue_with_lookup_core spq_checker #(
   .CAPACITY (CAPACITY),
   .CNT_BITS (CNT_BITS)
) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_push_dropped (rsp_push_dropped),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_is_empty     (rsp_is_empty)
);

// ===== tb/tb.sv =====
// self-checking testbench for the sorted priority queue with coordinate lookup
module tb;

   localparam int CAP     = spq_pkg::CAPACITY_DEFAULT;
   localparam int COST_W  = spq_pkg::COST_BITS_DEFAULT;
   localparam int COORD_W = spq_pkg::COORD_BITS_DEFAULT;
   localparam int CNT_W   = $clog2(CAP + 1);
   localparam int OP_W    = spq_pkg::OP_BITS;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [COST_W-1:0]  total_cost;
      logic [COST_W-1:0]  path_cost;
      logic [COST_W-1:0]  estimate_cost;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } open_entry_type;

   typedef struct packed {
      logic               found;
      logic [COST_W-1:0]  total_cost;
      logic [COST_W-1:0]  path_cost;
      logic [COST_W-1:0]  estimate_cost;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               push_dropped;
      logic [CNT_W-1:0]   entry_count;
      logic               is_empty;
   } queue_result_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op            = spq_pkg::OP_PUSH;
   logic [COST_W-1:0]   req_total_cost    = '0;
   logic [COST_W-1:0]   req_path_cost     = '0;
   logic [COST_W-1:0]   req_estimate_cost = '0;
   logic [COORD_W-1:0]  req_pos_x         = '0;
   logic [COORD_W-1:0]  req_pos_y         = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic                rsp_found;
   logic [COST_W-1:0]   rsp_out_total_cost;
   logic [COST_W-1:0]   rsp_out_path_cost;
   logic [COST_W-1:0]   rsp_out_estimate_cost;
   logic [COORD_W-1:0]  rsp_out_x;
   logic [COORD_W-1:0]  rsp_out_y;
   logic                rsp_push_dropped;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic                rsp_is_empty;

   // shadow copy of the open list and the responses it still owes
   open_entry_type   shadow_list[$];
   queue_result_type pending_results[$];

   int unsigned req_idle_pct  = 29;
   int unsigned rsp_stall_pct = 66;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;
   int unsigned errors        = 0;

   sorted_priority_queue_with_lookup_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_total_cost        (req_total_cost),
      .req_path_cost         (req_path_cost),
      .req_estimate_cost     (req_estimate_cost),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_found             (rsp_found),
      .rsp_out_total_cost    (rsp_out_total_cost),
      .rsp_out_path_cost     (rsp_out_path_cost),
      .rsp_out_estimate_cost (rsp_out_estimate_cost),
      .rsp_out_x             (rsp_out_x),
      .rsp_out_y             (rsp_out_y),
      .rsp_push_dropped      (rsp_push_dropped),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_is_empty          (rsp_is_empty)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("FAIL sorted_priority_queue_with_lookup_core");
      $finish;
   end

   // apply one accepted request to the shadow list and queue its response
   function automatic void model_queue_op(input logic [OP_W-1:0] op,
                                          input open_entry_type req);
      queue_result_type res;
      open_entry_type   head;
      int               pos;
      res = '0;
      case (op)
         spq_pkg::OP_PUSH: begin
            if (shadow_list.size() >= CAP) begin
               res.push_dropped = 1'b1;
            end else begin
               // ahead of the first entry with cost greater or equal
               pos = 0;
               while (pos < shadow_list.size() &&
                      shadow_list[pos].total_cost < req.total_cost)
                  pos++;
               shadow_list.insert(pos, req);
            end
         end
         spq_pkg::OP_POP: begin
            if (shadow_list.size() > 0) begin
               head                = shadow_list.pop_front();
               res.found           = 1'b1;
               res.total_cost      = head.total_cost;
               res.path_cost       = head.path_cost;
               res.estimate_cost   = head.estimate_cost;
               res.x               = head.x;
               res.y               = head.y;
            end
         end
         spq_pkg::OP_LOOKUP: begin
            // first match in queue order reports its total cost only
            for (int i = 0; i < shadow_list.size(); i++) begin
               if (shadow_list[i].x == req.x && shadow_list[i].y == req.y) begin
                  res.found      = 1'b1;
                  res.total_cost = shadow_list[i].total_cost;
                  break;
               end
            end
         end
         default: ;
      endcase
      res.entry_count = CNT_W'(shadow_list.size());
      res.is_empty    = (shadow_list.size() == 0);
      pending_results.push_back(res);
   endfunction

   // send one request, with a random idle gap ahead of it
   task automatic send_request(input logic [OP_W-1:0] op, input logic [COST_W-1:0] tc,
                               input logic [COST_W-1:0] pc, input logic [COST_W-1:0] ec,
                               input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      open_entry_type req;
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_total_cost    <= tc;
      req_path_cost     <= pc;
      req_estimate_cost <= ec;
      req_pos_x         <= x;
      req_pos_y         <= y;
      do @(posedge clock); while (req_stall);
      req = '{tc, pc, ec, x, y};
      model_queue_op(op, req);
   endtask

   // stop offering requests until every response is back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // costs cluster near zero so that equal keys are common
   function automatic logic [COST_W-1:0] random_cost();
      case ($urandom_range(3))
         0:       return COST_W'($urandom_range(7));
         1:       return COST_W'($urandom_range(255));
         2:       return COST_W'($urandom());
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      return $urandom_range(1) ? COORD_W'($urandom_range(3)) : COORD_W'($urandom());
   endfunction

   // one random request; lookups mostly aim at a held entry
   task automatic send_random(input logic [OP_W-1:0] op);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      int                 pick;
      x = random_coord();
      y = random_coord();
      if (op == spq_pkg::OP_LOOKUP && shadow_list.size() > 0 && $urandom_range(9) < 6) begin
         pick = $urandom_range(shadow_list.size() - 1);
         x    = shadow_list[pick].x;
         y    = shadow_list[pick].y;
      end
      send_request(op, random_cost(), random_cost(), random_cost(), x, y);
   endtask

   function automatic logic [OP_W-1:0] random_op(input int unsigned push_pct);
      int unsigned r;
      r = $urandom_range(99);
      if (r < push_pct) return spq_pkg::OP_PUSH;
      if (r < push_pct + (100 - push_pct) / 2) return spq_pkg::OP_POP;
      if (r < 98) return spq_pkg::OP_LOOKUP;
      return OP_UNUSED;
   endfunction

   // extremes, equal keys, zero-cost match, misses, empty pop and unused code
   task automatic test_directed_cases();
      send_request(spq_pkg::OP_POP,    '0, '0, '0, '0, '0);
      send_request(spq_pkg::OP_LOOKUP, '0, '0, '0, 10'd5, 10'd5);
      send_request(OP_UNUSED,          '0, '0, '0, '0, '0);
      send_request(spq_pkg::OP_PUSH,   16'd100, '1, '0, '1, '0);
      send_request(spq_pkg::OP_PUSH,   '0, '0, '1, '0, '1);
      send_request(spq_pkg::OP_PUSH,   '1, 16'h5555, 16'haaaa, 10'h2aa, 10'h155);
      send_request(spq_pkg::OP_PUSH,   '0, 16'd1, 16'd2, 10'd3, 10'd3);
      send_request(spq_pkg::OP_PUSH,   16'd100, 16'd7, 16'd7, '1, '0);
      send_request(spq_pkg::OP_LOOKUP, '1, '1, '1, '1, '0);
      send_request(spq_pkg::OP_LOOKUP, '0, '0, '0, '0, '1);
      send_request(spq_pkg::OP_LOOKUP, '0, '0, '0, 10'd1, 10'd1);
      send_request(OP_UNUSED,          '1, '1, '1, '1, '1);
      repeat (6) send_request(spq_pkg::OP_POP, '1, '1, '1, '1, '1);
      wait_drain();
   endtask

   // random traffic in fill, drain and mixed stretches
   task automatic test_random_traffic(input int n_items, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int issued;
      int unsigned push_pct;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      issued        = 0;
      while (issued < n_items) begin
         case ($urandom_range(9))
            0, 1: begin
               // fill to the top, overflow a few times, probe
               while (shadow_list.size() < CAP) begin
                  send_random(spq_pkg::OP_PUSH);
                  issued++;
               end
               repeat ($urandom_range(3, 1)) send_random(spq_pkg::OP_PUSH);
               repeat ($urandom_range(4)) send_random(spq_pkg::OP_LOOKUP);
               issued += 8;
            end
            2: begin
               // drain to empty and pop once more
               while (shadow_list.size() > 0) begin
                  send_random(spq_pkg::OP_POP);
                  issued++;
               end
               send_random(spq_pkg::OP_POP);
               issued++;
            end
            default: begin
               push_pct = $urandom_range(70, 30);
               repeat (50) send_random(random_op(push_pct));
               issued += 50;
            end
         endcase
      end
      wait_drain();
   endtask

   // long response hold-off while requests keep coming
   task automatic test_output_hold_off();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request <= 300;
      repeat (20) send_random(random_op(70));
      wait_drain();
   endtask

   // response stall, random or held off for a counted stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != 0) begin
         rsp_stall    <= 1'b1;
         hold_left    <= hold_request;
         hold_request <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // compare each accepted response with the oldest owed one
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected response: expected none, actual count %0d",
                     $time, rsp_entry_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("found",         32'(want.found),         32'(rsp_found));
            check_field("total_cost",    32'(want.total_cost),    32'(rsp_out_total_cost));
            check_field("path_cost",     32'(want.path_cost),     32'(rsp_out_path_cost));
            check_field("estimate_cost", 32'(want.estimate_cost),
                        32'(rsp_out_estimate_cost));
            check_field("x",             32'(want.x),             32'(rsp_out_x));
            check_field("y",             32'(want.y),             32'(rsp_out_y));
            check_field("push_dropped",  32'(want.push_dropped),  32'(rsp_push_dropped));
            check_field("entry_count",   32'(want.entry_count),   32'(rsp_entry_count));
            check_field("is_empty",      32'(want.is_empty),      32'(rsp_is_empty));
         end
      end
   end

   // test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(600, 29, 66);
      test_output_hold_off();
      test_random_traffic(600, 66, 29);
      test_random_traffic(600, 0, 0);
      wait_drain();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("PASS sorted_priority_queue_with_lookup_core");
      else
         $display("FAIL sorted_priority_queue_with_lookup_core");
      $finish;
   end

endmodule
